>>> design/ppd_pkg.sv
// ---------------------------------------------------------------------------
// ppd_pkg
// Shared constants, codes and types of the permutation power text decoder.
// ---------------------------------------------------------------------------
package ppd_pkg;

   localparam int MAX_LENGTH     = 64;
   localparam int COUNT_BITS     = 16;
   localparam int LEN_BITS       = $clog2(MAX_LENGTH + 1);
   localparam int POS_BITS       = $clog2(MAX_LENGTH);
   localparam int LVL_BITS       = $clog2(COUNT_BITS);
   localparam int BYTE_BITS      = 8;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam int JT_DEPTH       = COUNT_BITS * MAX_LENGTH;

   localparam logic [CSR_INDEX_BITS-1:0] REG_BLOCK_LENGTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_REPEAT_COUNT = CSR_INDEX_BITS'(1);

   localparam logic ACT_PERM = 1'b0;
   localparam logic ACT_TEXT = 1'b1;

   localparam logic [LVL_BITS-1:0] LVL_LAST = LVL_BITS'(COUNT_BITS - 1);
   localparam logic [LEN_BITS-1:0] LEN_MAX  = LEN_BITS'(MAX_LENGTH);

   typedef enum logic [1:0] {
      SRC_CTRL,
      SRC_DATA,
      SRC_CURSOR
   } rd_src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD_A,
      ST_BUILD_B,
      ST_BUILD_W,
      ST_WALK_INIT,
      ST_WALK_STEP,
      ST_WALK_DATA,
      ST_TEXT_RD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                 valid_clr;
      logic                 valid_set;
      logic                 jt_re;
      logic [LVL_BITS-1:0]  rd_lvl;
      rd_src_type           rd_src;
      logic                 jt_we;
      logic [LVL_BITS-1:0]  wr_lvl;
      logic                 wr_from_data;
      logic [POS_BITS-1:0]  wr_val;
      logic [POS_BITS-1:0]  pos;
      logic                 cur_load_pos;
      logic                 cur_load_data;
      logic                 txt_we;
      logic                 txt_re;
      logic                 emit;
      logic                 last;
   } ctrl_cmd_type;

endpackage

>>> design/permutation_power_text_decoder.sv
// ---------------------------------------------------------------------------
// permutation_power_text_decoder
// Undoes a transposition applied repeat_count times, using doubling levels.
//
// Usage: an item is taken when start is high and busy is low. Items with
// req_action low are permutation entries (req_target_position), one per
// source position; items with req_action high are text bytes (req_text_byte).
// Entries are taken only before the levels are built, text bytes only after.
// After the last of block_length entries the block builds the doubling
// levels with busy high: BUILD_A, BUILD_B and BUILD_W per entry and level.
// After the last text byte it walks each output position through the
// levels (WALK_INIT, WALK_STEP per level, WALK_DATA per set count bit,
// TEXT_RD, EMIT). Each decoded byte shows on rsp_decoded_byte for one cycle
// with rsp_valid high; rsp_last marks the final one. The receiver cannot
// stall. Registers (csr_we, csr_index, csr_wdata) must be written only while
// busy is low; the block does not enforce this. Reset returns the counters
// to empty, block_length and repeat_count to 1; the memories are not cleared.
// ---------------------------------------------------------------------------
module permutation_power_text_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [ppd_pkg::LEN_BITS-1:0]        req_target_position,
   input  logic [ppd_pkg::BYTE_BITS-1:0]       req_text_byte,
   output logic                                rsp_valid,
   output logic [ppd_pkg::BYTE_BITS-1:0]       rsp_decoded_byte,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [ppd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ppd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import ppd_pkg::*;

   ctrl_cmd_type cmd;

   ppd_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_target_position (req_target_position),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd)
   );

   ppd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_last         (rsp_last)
   );

endmodule

>>> design/ppd_datapath.sv
// ---------------------------------------------------------------------------
// ppd_datapath
// Jump table and text memories, level-0 valid bits, walk cursor and the
// result registers.
// ---------------------------------------------------------------------------
module ppd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ppd_pkg::ctrl_cmd_type           cmd,
   input  logic [ppd_pkg::BYTE_BITS-1:0]   req_text_byte,
   output logic                            rsp_valid,
   output logic [ppd_pkg::BYTE_BITS-1:0]   rsp_decoded_byte,
   output logic                            rsp_last
);
   import ppd_pkg::*;

   logic [POS_BITS-1:0]          jt_mem [0:JT_DEPTH-1];
   logic [BYTE_BITS-1:0]         txt_mem [0:MAX_LENGTH-1];

   logic [MAX_LENGTH-1:0]        valid_ff, valid_in;
   logic [POS_BITS-1:0]          jt_rdata_ff;
   logic                         hit_ff;
   logic [POS_BITS-1:0]          jt_data;
   logic [POS_BITS-1:0]          cur_ff, cur_in;
   logic [BYTE_BITS-1:0]         txt_rdata_ff;
   logic [POS_BITS-1:0]          rpos;
   logic [LVL_BITS+POS_BITS-1:0] raddr, waddr;
   logic [POS_BITS-1:0]          wdata;
   logic                         rsp_valid_ff;
   logic [BYTE_BITS-1:0]         rsp_byte_ff;
   logic                         rsp_last_ff;

   // level 0 entries not written in this block read as position 0
   assign jt_data = hit_ff ? jt_rdata_ff : '0;

   always_comb begin
      case (cmd.rd_src)
         SRC_CTRL:   rpos = cmd.pos;
         SRC_DATA:   rpos = jt_data;
         SRC_CURSOR: rpos = cur_ff;
         default:    rpos = cmd.pos;
      endcase
   end

   assign raddr = {cmd.rd_lvl, rpos};
   assign waddr = {cmd.wr_lvl, cmd.pos};
   assign wdata = cmd.wr_from_data ? jt_data : cmd.wr_val;

   always_comb begin
      valid_in = cmd.valid_clr ? '0 : valid_ff;
      if (cmd.valid_set) begin
         valid_in[cmd.pos] = 1'b1;
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.cur_load_pos) begin
         cur_in = cmd.pos;
      end else if (cmd.cur_load_data) begin
         cur_in = jt_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.jt_we) begin
         jt_mem[waddr] <= wdata;
      end
      if (cmd.jt_re) begin
         jt_rdata_ff <= jt_mem[raddr];
         hit_ff      <= (cmd.rd_lvl != '0) | valid_ff[rpos];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.txt_we) begin
         txt_mem[cmd.pos] <= req_text_byte;
      end
      if (cmd.txt_re) begin
         txt_rdata_ff <= txt_mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.emit) begin
         rsp_byte_ff <= txt_rdata_ff;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_decoded_byte = rsp_byte_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> design/ppd_ctrl.sv
// ---------------------------------------------------------------------------
// ppd_ctrl
// Control registers, item counters and the sequencer for loading, level
// build and the per-position walk.
// ---------------------------------------------------------------------------
module ppd_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [ppd_pkg::LEN_BITS-1:0]        req_target_position,
   input  logic                                csr_we,
   input  logic [ppd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ppd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output ppd_pkg::ctrl_cmd_type               cmd
);
   import ppd_pkg::*;

   state_type               state_ff, state_in;
   logic [LEN_BITS-1:0]     block_length_ff;
   logic [COUNT_BITS-1:0]   repeat_count_ff;
   logic [LEN_BITS-1:0]     perm_count_ff, perm_count_in;
   logic [LEN_BITS-1:0]     text_count_ff, text_count_in;
   logic                    table_ready_ff, table_ready_in;
   logic [LVL_BITS-1:0]     lvl_ff, lvl_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;

   logic [LEN_BITS-1:0]     eff_len;
   logic                    accept, perm_acc, text_acc, target_ok;
   logic [LEN_BITS-1:0]     perm_next, text_next, pos_next;
   logic                    perm_done, text_done, pos_last, lvl_last, rep_bit;

   always_comb begin
      if (block_length_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (block_length_ff > LEN_MAX) begin
         eff_len = LEN_MAX;
      end else begin
         eff_len = block_length_ff;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start & ~busy;
   assign perm_acc  = accept & (req_action == ACT_PERM) & ~table_ready_ff;
   assign text_acc  = accept & (req_action == ACT_TEXT) & table_ready_ff;
   assign target_ok = (req_target_position != '0) && (req_target_position <= eff_len);
   assign perm_next = perm_count_ff + LEN_BITS'(1);
   assign text_next = text_count_ff + LEN_BITS'(1);
   assign pos_next  = {1'b0, pos_ff} + LEN_BITS'(1);
   assign perm_done = (perm_next >= eff_len);
   assign text_done = (text_next >= eff_len);
   assign pos_last  = (pos_next >= eff_len);
   assign lvl_last  = (lvl_ff == LVL_LAST);
   assign rep_bit   = repeat_count_ff[lvl_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (perm_acc && perm_done) begin
               state_in = ST_BUILD_A;
            end else if (text_acc && text_done) begin
               state_in = ST_WALK_INIT;
            end
         end
         ST_BUILD_A: state_in = ST_BUILD_B;
         ST_BUILD_B: state_in = ST_BUILD_W;
         ST_BUILD_W: begin
            state_in = (pos_last && lvl_last) ? ST_IDLE : ST_BUILD_A;
         end
         ST_WALK_INIT: state_in = ST_WALK_STEP;
         ST_WALK_STEP: begin
            if (rep_bit) begin
               state_in = ST_WALK_DATA;
            end else if (lvl_last) begin
               state_in = ST_TEXT_RD;
            end
         end
         ST_WALK_DATA: state_in = lvl_last ? ST_TEXT_RD : ST_WALK_STEP;
         ST_TEXT_RD:   state_in = ST_EMIT;
         ST_EMIT:      state_in = pos_last ? ST_IDLE : ST_WALK_INIT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      perm_count_in  = perm_count_ff;
      text_count_in  = text_count_ff;
      table_ready_in = table_ready_ff;
      lvl_in         = lvl_ff;
      pos_in         = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (perm_acc) begin
               perm_count_in = perm_done ? '0 : perm_next;
               lvl_in        = LVL_BITS'(1);
               pos_in        = '0;
            end
            if (text_acc) begin
               text_count_in = text_done ? '0 : text_next;
               pos_in        = '0;
            end
         end
         ST_BUILD_W: begin
            if (pos_last) begin
               pos_in = '0;
               lvl_in = lvl_ff + LVL_BITS'(1);
               if (lvl_last) begin
                  table_ready_in = 1'b1;
               end
            end else begin
               pos_in = pos_next[POS_BITS-1:0];
            end
         end
         ST_WALK_INIT: lvl_in = '0;
         ST_WALK_STEP: begin
            if (!rep_bit && !lvl_last) begin
               lvl_in = lvl_ff + LVL_BITS'(1);
            end
         end
         ST_WALK_DATA: begin
            if (!lvl_last) begin
               lvl_in = lvl_ff + LVL_BITS'(1);
            end
         end
         ST_EMIT: begin
            if (pos_last) begin
               table_ready_in = 1'b0;
            end else begin
               pos_in = pos_next[POS_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.rd_src = SRC_CTRL;
      case (state_ff)
         ST_IDLE: begin
            if (perm_acc) begin
               cmd.valid_clr = (perm_count_ff == '0);
               if (target_ok) begin
                  cmd.valid_set = 1'b1;
                  cmd.jt_we     = 1'b1;
                  cmd.wr_val    = perm_count_ff[POS_BITS-1:0];
                  cmd.pos       = POS_BITS'(req_target_position - LEN_BITS'(1));
               end
            end
            if (text_acc) begin
               cmd.txt_we = 1'b1;
               cmd.pos    = text_count_ff[POS_BITS-1:0];
            end
         end
         ST_BUILD_A: begin
            cmd.jt_re  = 1'b1;
            cmd.rd_lvl = lvl_ff - LVL_BITS'(1);
            cmd.pos    = pos_ff;
         end
         ST_BUILD_B: begin
            cmd.jt_re  = 1'b1;
            cmd.rd_lvl = lvl_ff - LVL_BITS'(1);
            cmd.rd_src = SRC_DATA;
         end
         ST_BUILD_W: begin
            cmd.jt_we        = 1'b1;
            cmd.wr_lvl       = lvl_ff;
            cmd.wr_from_data = 1'b1;
            cmd.pos          = pos_ff;
         end
         ST_WALK_INIT: begin
            cmd.cur_load_pos = 1'b1;
            cmd.pos          = pos_ff;
         end
         ST_WALK_STEP: begin
            cmd.jt_re  = rep_bit;
            cmd.rd_lvl = lvl_ff;
            cmd.rd_src = SRC_CURSOR;
         end
         ST_WALK_DATA: cmd.cur_load_data = 1'b1;
         ST_TEXT_RD:   cmd.txt_re = 1'b1;
         ST_EMIT: begin
            cmd.emit = 1'b1;
            cmd.last = pos_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         block_length_ff <= LEN_BITS'(1);
         repeat_count_ff <= COUNT_BITS'(1);
         perm_count_ff   <= '0;
         text_count_ff   <= '0;
         table_ready_ff  <= 1'b0;
         lvl_ff          <= '0;
         pos_ff          <= '0;
      end else begin
         state_ff       <= state_in;
         perm_count_ff  <= perm_count_in;
         text_count_ff  <= text_count_in;
         table_ready_ff <= table_ready_in;
         lvl_ff         <= lvl_in;
         pos_ff         <= pos_in;
         if (csr_we && csr_index == REG_BLOCK_LENGTH) begin
            block_length_ff <= csr_wdata[LEN_BITS-1:0];
         end
         if (csr_we && csr_index == REG_REPEAT_COUNT) begin
            repeat_count_ff <= csr_wdata[COUNT_BITS-1:0];
         end
      end
   end

endmodule
